// File: rtl/core/lowest_free_id_allocator_assert.svh
// Assertion macros shared by the lowest-free id allocator RTL.
// Included by the modules that carry concurrent checks; needs clock and reset in scope.
`ifndef LOWEST_FREE_ID_ALLOCATOR_ASSERT_SVH
`define LOWEST_FREE_ID_ALLOCATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define LFIA_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lowest_free_id_allocator: same-cycle check failed");

`define LFIA_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lowest_free_id_allocator: next-cycle check failed");

`else

`define LFIA_IMPLY(label, ante, cons)

`define LFIA_NEXT(label, ante, cons)

`endif

`endif

// File: rtl/core/lfia_pkg.sv
// Package for the lowest-free id allocator: sizes of the id space and bitmap,
// payload codes, controller states and the bitmap access struct. No dependencies.
`default_nettype none

package lfia_pkg;

   localparam int ID_COUNT      = 1024;
   // Must be a power of two.
   localparam int WORD_BITS     = 64;
   localparam int ID_W          = 10;
   localparam int STATUS_W      = 2;
   localparam int ID_FIELD_SPAN = 1 << ID_W;
   localparam int USABLE_IDS    = (ID_COUNT < ID_FIELD_SPAN) ? ID_COUNT : ID_FIELD_SPAN;
   localparam int BIT_W         = $clog2(WORD_BITS);
   localparam int USED_WORDS    = (USABLE_IDS + WORD_BITS - 1) / WORD_BITS;
   localparam int LAST_WORD     = USED_WORDS - 1;
   localparam int WADDR_W       = (USED_WORDS > 1) ? $clog2(USED_WORDS) : 1;
   localparam int LAST_BIT      = (USABLE_IDS - 1) % WORD_BITS;

   // Bits of the last word that map to ids inside the usable space.
   localparam logic [WORD_BITS-1:0] TOP_MASK =
      {WORD_BITS{1'b1}} >> (WORD_BITS - 1 - LAST_BIT);

   typedef enum logic {
      MODE_REQUEST = 1'b0,
      MODE_RELEASE = 1'b1
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_GRANTED   = 2'd0,
      STATUS_NONE_FREE = 2'd1,
      STATUS_RELEASED  = 2'd2,
      STATUS_IGNORED   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_CHECK,
      S_DONE
   } state_type;

   typedef struct packed {
      logic                 rd_en;
      logic [WADDR_W-1:0]   rd_addr;
      logic                 wr_en;
      logic [WADDR_W-1:0]   wr_addr;
      logic [WORD_BITS-1:0] wr_data;
   } map_req_type;

endpackage

`default_nettype wire

// File: rtl/core/lfia_req_if.sv
// Request channel of the id allocator: valid/ready handshake with mode and id payload.
// Depends on lfia_pkg for the field widths.
`default_nettype none

interface lfia_req_if;
   import lfia_pkg::*;

   logic            valid;
   logic            ready;
   logic            mode;
   logic [ID_W-1:0] id_value;

   modport source (output valid, output mode, output id_value, input ready);
   modport sink   (input valid, input mode, input id_value, output ready);
endinterface

`default_nettype wire

// File: rtl/core/lfia_rsp_if.sv
// Response channel of the id allocator: valid/ready handshake with id and status payload.
// Depends on lfia_pkg for the field widths.
`default_nettype none

interface lfia_rsp_if;
   import lfia_pkg::*;

   logic                valid;
   logic                ready;
   logic [ID_W-1:0]     result_id;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output result_id, output status, input ready);
   modport sink   (input valid, input result_id, input status, output ready);
endinterface

`default_nettype wire

// File: rtl/core/lfia_bitmap.sv
// Used-id bitmap: one word per WORD_BITS ids, single write and single registered read port.
// Per-word valid bits make never-written words read as all free. Depends on lfia_pkg.
`default_nettype none

module lfia_bitmap (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire lfia_pkg::map_req_type          map_req,
   output logic [lfia_pkg::WORD_BITS-1:0]      rd_word
);
   import lfia_pkg::*;

   logic [WORD_BITS-1:0]  mem_ff [USED_WORDS];
   logic [USED_WORDS-1:0] valid_ff;
   logic [WORD_BITS-1:0]  rd_data_ff;
   logic                  rd_valid_ff;

   always_ff @(posedge clock) begin
      if (map_req.wr_en) begin
         mem_ff[map_req.wr_addr] <= map_req.wr_data;
      end
      if (map_req.rd_en) begin
         rd_data_ff  <= mem_ff[map_req.rd_addr];
         rd_valid_ff <= valid_ff[map_req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (map_req.wr_en) begin
         valid_ff[map_req.wr_addr] <= 1'b1;
      end
   end

   assign rd_word = rd_valid_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

// File: rtl/core/lfia_ctrl.sv
// Sequencer of the id allocator: accepts beats, walks the bitmap one word per cycle
// through a shared priority encoder, updates it and holds the response. Uses lfia_pkg.
`default_nettype none

`include "lowest_free_id_allocator_assert.svh"

module lfia_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   lfia_req_if.sink                       req_bus,
   lfia_rsp_if.source                     rsp_bus,
   output lfia_pkg::map_req_type          map_req,
   input  wire logic [lfia_pkg::WORD_BITS-1:0] rd_word
);
   import lfia_pkg::*;

   state_type           state_ff, state_in;
   mode_type            mode_ff, mode_in;
   logic [ID_W-1:0]     id_ff, id_in;
   logic [WADDR_W-1:0]  chk_word_ff, chk_word_in;
   logic                first_ff, first_in;
   logic [ID_W-1:0]     res_id_ff, res_id_in;
   status_type          res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]     rsp_id_ff;
   status_type          rsp_status_ff;

   logic [WORD_BITS-1:0] start_mask;
   logic [WORD_BITS-1:0] end_mask;
   logic [WORD_BITS-1:0] free_vec;
   logic [WORD_BITS-1:0] grant_bit;
   logic [WORD_BITS-1:0] release_bit;
   logic [BIT_W-1:0]     free_idx;
   logic                 found;
   logic                 last_word;
   logic                 used_bit;
   logic                 in_range;
   logic                 slot_free;
   logic                 rsp_load;
   logic [ID_W-1:0]      grant_id;
   logic [WADDR_W-1:0]   req_word;

   // Shared search unit over the current bitmap word.
   always_comb begin
      start_mask = first_ff ? ({WORD_BITS{1'b1}} << id_ff[BIT_W-1:0]) : {WORD_BITS{1'b1}};
      last_word  = (chk_word_ff == WADDR_W'(LAST_WORD));
      end_mask   = last_word ? TOP_MASK : {WORD_BITS{1'b1}};
      free_vec   = ~rd_word & start_mask & end_mask;
      found      = |free_vec;
      free_idx   = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (free_vec[i]) begin
            free_idx = BIT_W'(i);
         end
      end
      grant_bit   = {{(WORD_BITS-1){1'b0}}, 1'b1} << free_idx;
      release_bit = {{(WORD_BITS-1){1'b0}}, 1'b1} << id_ff[BIT_W-1:0];
      grant_id    = (ID_W'(chk_word_ff) << BIT_W) | ID_W'(free_idx);
      used_bit    = rd_word[id_ff[BIT_W-1:0]];
      in_range    = ({1'b0, req_bus.id_value} < (ID_W+1)'(USABLE_IDS));
      req_word    = WADDR_W'(req_bus.id_value >> BIT_W);
      slot_free   = !rsp_valid_ff || rsp_bus.ready;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               if (!in_range) begin
                  state_in = S_DONE;
               end else if (mode_type'(req_bus.mode) == MODE_RELEASE) begin
                  state_in = S_CHECK;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (found || last_word) begin
               state_in = S_DONE;
            end
         end
         S_CHECK: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_bus.ready = (state_ff == S_IDLE);
      map_req       = '0;
      mode_in       = mode_ff;
      id_in         = id_ff;
      chk_word_in   = chk_word_ff;
      first_in      = first_ff;
      res_id_in     = res_id_ff;
      res_status_in = res_status_ff;
      rsp_load      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               mode_in         = mode_type'(req_bus.mode);
               id_in           = req_bus.id_value;
               chk_word_in     = req_word;
               first_in        = 1'b1;
               map_req.rd_en   = 1'b1;
               map_req.rd_addr = req_word;
               if (mode_type'(req_bus.mode) == MODE_RELEASE) begin
                  res_id_in     = req_bus.id_value;
                  res_status_in = STATUS_IGNORED;
               end else begin
                  res_id_in     = '0;
                  res_status_in = STATUS_NONE_FREE;
               end
            end
         end
         S_SCAN: begin
            map_req.rd_en   = 1'b1;
            map_req.rd_addr = chk_word_ff + 1'b1;
            chk_word_in     = chk_word_ff + 1'b1;
            first_in        = 1'b0;
            if (found) begin
               map_req.wr_en   = 1'b1;
               map_req.wr_addr = chk_word_ff;
               map_req.wr_data = rd_word | grant_bit;
               res_id_in       = grant_id;
               res_status_in   = STATUS_GRANTED;
            end
         end
         S_CHECK: begin
            if (used_bit) begin
               map_req.wr_en   = 1'b1;
               map_req.wr_addr = chk_word_ff;
               map_req.wr_data = rd_word & ~release_bit;
               res_status_in   = STATUS_RELEASED;
            end
         end
         S_DONE: begin
            rsp_load = slot_free;
         end
         default: begin
         end
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      id_ff         <= id_in;
      chk_word_ff   <= chk_word_in;
      first_ff      <= first_in;
      res_id_ff     <= res_id_in;
      res_status_ff <= res_status_in;
      if (rsp_load) begin
         rsp_id_ff     <= res_id_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.result_id = rsp_id_ff;
   assign rsp_bus.status    = rsp_status_ff;

   `LFIA_IMPLY(a_grant_at_or_above, state_ff == S_DONE && mode_ff == MODE_REQUEST && res_status_ff == STATUS_GRANTED, res_id_ff >= id_ff)
   `LFIA_IMPLY(a_release_echo, state_ff == S_DONE && mode_ff == MODE_RELEASE, res_id_ff == id_ff && (res_status_ff == STATUS_RELEASED || res_status_ff == STATUS_IGNORED))
   `LFIA_IMPLY(a_write_when_working, map_req.wr_en, state_ff == S_SCAN || state_ff == S_CHECK)
   `LFIA_IMPLY(a_scan_bounded, state_ff == S_SCAN, chk_word_ff <= WADDR_W'(LAST_WORD))
   `LFIA_NEXT(a_accept_leaves_idle, req_bus.valid && req_bus.ready, state_ff != S_IDLE)

endmodule

`default_nettype wire

// File: rtl/core/lowest_free_id_allocator.sv
// Lowest-free id allocator. A request beat carries a lowest acceptable id and gets back the
// smallest free id at or above it, which is then marked used; a release beat frees one id and
// is reported as ignored when that id was not in use. An id outside the usable space goes
// straight to the response, as none free for a request and as ignored for a release. The used
// bitmap is a memory of WORD_BITS-wide words, read one word per cycle and searched by one
// priority encoder. A request walks the words from the one holding the requested id to the
// first word with a free id (at most 16 with 1024 ids in 64-bit words); a release reads and
// checks only the word holding its id. The response is registered; the block is ready again
// when it is loaded, which waits for any earlier response to be taken. The block takes one
// beat at a time. Reset clears the bitmap at once through per-word valid bits.
`default_nettype none

module lowest_free_id_allocator (
   input  wire logic  clock,
   input  wire logic  reset,
   lfia_req_if.sink   req_bus,
   lfia_rsp_if.source rsp_bus
);
   import lfia_pkg::*;

   map_req_type          map_req;
   logic [WORD_BITS-1:0] rd_word;

   lfia_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .map_req (map_req),
      .rd_word (rd_word)
   );

   lfia_bitmap u_bitmap (
      .clock   (clock),
      .reset   (reset),
      .map_req (map_req),
      .rd_word (rd_word)
   );

endmodule

`default_nettype wire
